[rtl/core/rrjd_pkg.sv]
// Shared types, constants and helper functions for the rotating-rule job dispatcher.
`timescale 1ns / 1ps

package rrjd_pkg;

  localparam int MAX_JOBS        = 16;
  localparam int MAX_OPS_PER_JOB = 16;
  localparam int SLOT_W          = $clog2(MAX_JOBS);
  localparam int IDX_W           = $clog2(MAX_OPS_PER_JOB);
  localparam int CNT_W           = IDX_W + 1;
  localparam int JOB_CNT_W       = SLOT_W + 1;
  localparam int MEM_DEPTH       = MAX_JOBS * MAX_OPS_PER_JOB;
  localparam int MEM_AW          = SLOT_W + IDX_W;
  localparam int TOTAL_W         = $clog2(MEM_DEPTH + 1);
  localparam int ID_W            = 16;
  localparam int COST_W          = 20;
  localparam int WEIGHT_W        = COST_W + IDX_W + 1;
  localparam int CFG_W           = 16;
  localparam int CFG_IDX_W       = 2;
  localparam int NUM_RULES       = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_DET_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RULE_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED       = 2'd2;

  localparam logic [15:0] LFSR_TAPS = 16'hB400;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_ISSUED   = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_PICK,
    S_READ,
    S_UPDATE,
    S_FIND,
    S_COPY,
    S_COMMIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              req_type;
    logic [ID_W-1:0]   job_id;
    logic [ID_W-1:0]   op_id;
    logic [COST_W-1:0] op_cost;
    logic              last_of_job;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [ID_W-1:0]    out_job_id;
    logic [ID_W-1:0]    out_op_id;
    logic [1:0]         rule_used;
    logic [TOTAL_W-1:0] remaining_ops;
  } out_item_t;

  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic [ID_W-1:0]   op;
  } op_entry_t;

  typedef struct packed {
    logic latch;
    logic add_eval;
    logic pop_eval;
    logic scan_step;
    logic pick;
    logic mem_read;
    logic update;
    logic find;
    logic copy_step;
    logic commit;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic is_pop;
    logic add_overflow;
    logic add_last;
    logic pop_empty;
    logic scan_last;
    logic slot_found;
    logic copy_last;
    logic out_free;
  } sts_t;

  // Remainder of v by an effective rule count of 1 to 4. The mod-3 case folds
  // base-4 digits, since 4 is congruent to 1 modulo 3.
  function automatic logic [1:0] rule_mod(input logic [15:0] v, input logic [2:0] n);
    logic [4:0] dsum;
    logic [2:0] fold;
    logic [1:0] m3;
    logic [1:0] r;
    dsum = '0;
    for (int i = 0; i < 8; i++) begin
      dsum = dsum + 5'(v[2*i +: 2]);
    end
    fold = 3'(dsum[1:0]) + 3'(dsum[3:2]) + 3'(dsum[4]);
    priority if (fold >= 3'd6) begin
      m3 = 2'(fold - 3'd6);
    end else if (fold >= 3'd3) begin
      m3 = 2'(fold - 3'd3);
    end else begin
      m3 = fold[1:0];
    end
    unique case (n)
      3'd2: r = {1'b0, v[0]};
      3'd3: r = m3;
      3'd4: r = v[1:0];
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/rrjd_ctrl.sv]
// Controller state machine that sequences add, close and pop transactions.
`timescale 1ns / 1ps

module rrjd_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  rrjd_pkg::sts_t sts,
  output rrjd_pkg::cmd_t cmd
);

  rrjd_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rrjd_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      rrjd_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = rrjd_pkg::S_DECODE;
        end
      end
      rrjd_pkg::S_DECODE: begin
        if (sts.is_pop) begin
          cmd.pop_eval = 1'b1;
          state_nxt    = sts.pop_empty ? rrjd_pkg::S_DONE : rrjd_pkg::S_SCAN;
        end else begin
          cmd.add_eval = 1'b1;
          if (!sts.add_overflow && sts.add_last) begin
            state_nxt = rrjd_pkg::S_FIND;
          end else begin
            state_nxt = rrjd_pkg::S_DONE;
          end
        end
      end
      rrjd_pkg::S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = rrjd_pkg::S_PICK;
        end
      end
      rrjd_pkg::S_PICK: begin
        cmd.pick  = 1'b1;
        state_nxt = rrjd_pkg::S_READ;
      end
      rrjd_pkg::S_READ: begin
        cmd.mem_read = 1'b1;
        state_nxt    = rrjd_pkg::S_UPDATE;
      end
      rrjd_pkg::S_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = rrjd_pkg::S_DONE;
      end
      rrjd_pkg::S_FIND: begin
        cmd.find  = 1'b1;
        state_nxt = sts.slot_found ? rrjd_pkg::S_COPY : rrjd_pkg::S_DONE;
      end
      rrjd_pkg::S_COPY: begin
        cmd.copy_step = 1'b1;
        if (sts.copy_last) begin
          state_nxt = rrjd_pkg::S_COMMIT;
        end
      end
      rrjd_pkg::S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = rrjd_pkg::S_DONE;
      end
      rrjd_pkg::S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = rrjd_pkg::S_IDLE;
        end
      end
      default: state_nxt = rrjd_pkg::S_IDLE;
    endcase
  end

  assign in_stall = (state_r != rrjd_pkg::S_IDLE);

`ifndef SYNTHESIS
  // A new transaction is only latched from idle, and the next cycle decodes it.
  a_latch_to_decode: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.latch |=> state_r == rrjd_pkg::S_DECODE)
    else $error("latched transaction not decoded");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rrjd_pkg::S_DONE) && !sts.out_free |=> state_r == rrjd_pkg::S_DONE)
    else $error("result dropped while the output register was busy");

  a_scan_to_pick: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rrjd_pkg::S_SCAN) && sts.scan_last |=> state_r == rrjd_pkg::S_PICK)
    else $error("slot scan did not end in pick");
`endif

endmodule

[rtl/core/rrjd_dpath.sv]
// Datapath: staging buffer, job table, operation memory, rule selection and result register.
`timescale 1ns / 1ps

module rrjd_dpath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [rrjd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rrjd_pkg::CFG_W-1:0]          cfg_wdata,
  input  rrjd_pkg::in_item_t                  in_item,
  output logic                                out_valid,
  input  logic                                out_stall,
  output rrjd_pkg::out_item_t                 out_item,
  input  rrjd_pkg::cmd_t                      cmd,
  output rrjd_pkg::sts_t                      sts
);

  // Configuration and rule state.
  logic        det_r;
  logic [2:0]  rcnt_r;
  logic [15:0] lfsr_r;
  logic [1:0]  rule_r;

  rrjd_pkg::in_item_t in_q_r;

  // Staging buffer, kept sorted by cost as operations arrive.
  rrjd_pkg::op_entry_t                  stage_r [rrjd_pkg::MAX_OPS_PER_JOB];
  rrjd_pkg::op_entry_t                  stage_ins [rrjd_pkg::MAX_OPS_PER_JOB];
  logic [rrjd_pkg::CNT_W-1:0]           stage_len_r;
  logic [rrjd_pkg::ID_W-1:0]            stage_job_r;
  logic [rrjd_pkg::WEIGHT_W-1:0]        stage_sum_r;
  logic [rrjd_pkg::CNT_W-1:0]           eff_len;
  logic [rrjd_pkg::MAX_OPS_PER_JOB-1:0] le;
  logic                                 add_overflow;
  rrjd_pkg::op_entry_t                  new_entry;

  // Job table.
  logic [rrjd_pkg::ID_W-1:0]     ids_r    [rrjd_pkg::MAX_JOBS];
  logic [rrjd_pkg::MAX_JOBS-1:0] valid_r;
  logic [rrjd_pkg::IDX_W-1:0]    head_r   [rrjd_pkg::MAX_JOBS];
  logic [rrjd_pkg::CNT_W-1:0]    count_r  [rrjd_pkg::MAX_JOBS];
  logic [rrjd_pkg::WEIGHT_W-1:0] live_r   [rrjd_pkg::MAX_JOBS];
  logic [rrjd_pkg::WEIGHT_W-1:0] weight_r [rrjd_pkg::MAX_JOBS];
  logic [rrjd_pkg::TOTAL_W-1:0]  total_r;
  logic [rrjd_pkg::SLOT_W-1:0]   rot_r;

  // Operation memory.
  rrjd_pkg::op_entry_t mem [rrjd_pkg::MEM_DEPTH];
  rrjd_pkg::op_entry_t mem_q_r;

  // Slot scan and selection.
  logic [rrjd_pkg::SLOT_W-1:0]   scan_r;
  logic [rrjd_pkg::IDX_W-1:0]    copy_r;
  logic                          min_found_r, rk_found_r;
  logic [rrjd_pkg::SLOT_W-1:0]   min_slot_r, rk_slot_r, slot_r;
  logic [rrjd_pkg::WEIGHT_W-1:0] min_w_r;
  logic [rrjd_pkg::ID_W-1:0]     min_id_r, rk_id_r, pick_id_r;

  logic [rrjd_pkg::JOB_CNT_W-1:0] n_jobs, n_after, rank, rp1, rp1_wrap;
  logic [rrjd_pkg::ID_W-1:0]      s_id;
  logic                           s_valid, rank_hit, min_take, pop_empty;
  logic [2:0]                     neff;
  logic [15:0]                    lfsr_step;
  logic [1:0]                     rule_new;
  logic                           m_any, f_any, found;
  logic [rrjd_pkg::SLOT_W-1:0]    m_slot, f_slot;
  logic [rrjd_pkg::IDX_W-1:0]     rd_idx;
  logic                           last_op;
  logic [rrjd_pkg::SLOT_W-1:0]    rot_nxt;
  logic                           out_valid_r;
  rrjd_pkg::out_item_t            res_r, out_item_r, res_nxt, out_item_nxt;

  // ---------------- configuration and LFSR ----------------
  always_comb begin
    lfsr_step = {1'b0, lfsr_r[15:1]} ^ (lfsr_r[0] ? rrjd_pkg::LFSR_TAPS : 16'h0000);
    priority if (rcnt_r == 3'd0) begin
      neff = 3'd1;
    end else if (rcnt_r > 3'(rrjd_pkg::NUM_RULES)) begin
      neff = 3'(rrjd_pkg::NUM_RULES);
    end else begin
      neff = rcnt_r;
    end
    if (det_r) begin
      rule_new = rrjd_pkg::rule_mod({14'd0, rule_r} + 16'd1, neff);
    end else begin
      rule_new = rrjd_pkg::rule_mod(lfsr_step, neff);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      det_r  <= 1'b1;
      rcnt_r <= 3'(rrjd_pkg::NUM_RULES);
      lfsr_r <= 16'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rrjd_pkg::CFG_DET_MODE:   det_r  <= cfg_wdata[0];
        rrjd_pkg::CFG_RULE_COUNT: rcnt_r <= cfg_wdata[2:0];
        rrjd_pkg::CFG_SEED:       lfsr_r <= (cfg_wdata == '0) ? 16'd1 : cfg_wdata;
        default: ;
      endcase
    end else if (cmd.pop_eval && !pop_empty && !det_r) begin
      lfsr_r <= lfsr_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      in_q_r <= in_item;
    end
  end

  // ---------------- staging ----------------
  always_comb begin
    new_entry.cost = in_q_r.op_cost;
    new_entry.op   = in_q_r.op_id;
    if (stage_len_r != '0 && stage_job_r != in_q_r.job_id) begin
      eff_len = '0;
    end else begin
      eff_len = stage_len_r;
    end
    add_overflow = (eff_len == rrjd_pkg::CNT_W'(rrjd_pkg::MAX_OPS_PER_JOB));
    for (int i = 0; i < rrjd_pkg::MAX_OPS_PER_JOB; i++) begin
      le[i] = (rrjd_pkg::CNT_W'(i) < eff_len) && (stage_r[i].cost <= in_q_r.op_cost);
    end
    // Entries no costlier than the new one stay; the new one goes right after
    // them, which keeps equal costs in arrival order.
    stage_ins[0] = le[0] ? stage_r[0] : new_entry;
    for (int i = 1; i < rrjd_pkg::MAX_OPS_PER_JOB; i++) begin
      if (le[i]) begin
        stage_ins[i] = stage_r[i];
      end else if (le[i-1]) begin
        stage_ins[i] = new_entry;
      end else begin
        stage_ins[i] = stage_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_len_r <= '0;
    end else if (cmd.add_eval) begin
      stage_len_r <= add_overflow ? '0 : eff_len + 1'b1;
    end else if ((cmd.find && !found) || cmd.commit) begin
      stage_len_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add_eval && !add_overflow) begin
      stage_job_r <= in_q_r.job_id;
      stage_r     <= stage_ins;
      stage_sum_r <= ((eff_len == '0) ? '0 : stage_sum_r)
                     + rrjd_pkg::WEIGHT_W'(in_q_r.op_cost);
    end
  end

  // ---------------- slot lookup for a close ----------------
  always_comb begin
    m_any  = 1'b0;
    f_any  = 1'b0;
    m_slot = '0;
    f_slot = '0;
    for (int s = rrjd_pkg::MAX_JOBS - 1; s >= 0; s--) begin
      if (valid_r[s] && ids_r[s] == stage_job_r) begin
        m_any  = 1'b1;
        m_slot = rrjd_pkg::SLOT_W'(s);
      end
      if (!valid_r[s]) begin
        f_any  = 1'b1;
        f_slot = rrjd_pkg::SLOT_W'(s);
      end
    end
    found = m_any || f_any;
  end

  // ---------------- scan for a pop ----------------
  always_comb begin
    n_jobs = '0;
    for (int t = 0; t < rrjd_pkg::MAX_JOBS; t++) begin
      n_jobs = n_jobs + rrjd_pkg::JOB_CNT_W'(valid_r[t]);
    end
    pop_empty = (total_r == '0) || (n_jobs == '0);
    s_id      = ids_r[scan_r];
    s_valid   = valid_r[scan_r];
    rank      = '0;
    for (int t = 0; t < rrjd_pkg::MAX_JOBS; t++) begin
      rank = rank + rrjd_pkg::JOB_CNT_W'(valid_r[t] && (ids_r[t] < s_id));
    end
    rank_hit = s_valid && !rk_found_r && (rank == {1'b0, rot_r});
    min_take = s_valid && (!min_found_r || (weight_r[scan_r] < min_w_r) ||
               ((weight_r[scan_r] == min_w_r) && (s_id < min_id_r)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r      <= '0;
      min_found_r <= 1'b0;
      rk_found_r  <= 1'b0;
    end else if (cmd.pop_eval) begin
      scan_r      <= '0;
      min_found_r <= 1'b0;
      rk_found_r  <= 1'b0;
    end else if (cmd.scan_step) begin
      scan_r <= scan_r + 1'b1;
      if (min_take) begin
        min_found_r <= 1'b1;
      end
      if (rank_hit) begin
        rk_found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step && min_take) begin
      min_slot_r <= scan_r;
      min_w_r    <= weight_r[scan_r];
      min_id_r   <= s_id;
    end
    if (cmd.scan_step && rank_hit) begin
      rk_slot_r <= scan_r;
      rk_id_r   <= s_id;
    end
    // Rules 0 and 1 take the lightest job; rules 2 and 3 the round-robin job.
    if (cmd.pick) begin
      slot_r    <= rule_r[1] ? rk_slot_r : min_slot_r;
      pick_id_r <= rule_r[1] ? rk_id_r : min_id_r;
    end else if (cmd.find && found) begin
      slot_r <= m_any ? m_slot : f_slot;
    end
    if (cmd.find) begin
      copy_r <= '0;
    end else if (cmd.copy_step) begin
      copy_r <= copy_r + 1'b1;
    end
  end

  // ---------------- operation memory ----------------
  // Odd rules take the cheapest op at the head, even rules the costliest at the tail.
  assign rd_idx = rule_r[0] ? head_r[slot_r]
                            : head_r[slot_r] + count_r[slot_r][rrjd_pkg::IDX_W-1:0] - 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.copy_step) begin
      mem[{slot_r, copy_r}] <= stage_r[copy_r];
    end
    if (cmd.mem_read) begin
      mem_q_r <= mem[{slot_r, rd_idx}];
    end
  end

  // ---------------- job table update ----------------
  always_comb begin
    last_op  = (count_r[slot_r] == rrjd_pkg::CNT_W'(1));
    n_after  = n_jobs - rrjd_pkg::JOB_CNT_W'(last_op);
    rp1      = {1'b0, rot_r} + 1'b1;
    rp1_wrap = rp1 - n_after;
    // The advanced position can exceed the shrunken job count by one, which
    // with a single job left needs a second wrap.
    priority if (n_after == '0) begin
      rot_nxt = '0;
    end else if (!rule_r[1]) begin
      rot_nxt = ({1'b0, rot_r} >= n_after) ? rrjd_pkg::SLOT_W'({1'b0, rot_r} - n_after)
                                           : rot_r;
    end else if (rp1 < n_after) begin
      rot_nxt = rrjd_pkg::SLOT_W'(rp1);
    end else if (rp1_wrap >= n_after) begin
      rot_nxt = rrjd_pkg::SLOT_W'(rp1_wrap - n_after);
    end else begin
      rot_nxt = rrjd_pkg::SLOT_W'(rp1_wrap);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      total_r <= '0;
      rot_r   <= '0;
      rule_r  <= '0;
      for (int s = 0; s < rrjd_pkg::MAX_JOBS; s++) begin
        head_r[s]   <= '0;
        count_r[s]  <= '0;
        live_r[s]   <= '0;
        weight_r[s] <= '0;
      end
    end else begin
      if (cmd.pop_eval && !pop_empty) begin
        rule_r <= rule_new;
      end
      if (cmd.commit) begin
        valid_r[slot_r] <= 1'b1;
        head_r[slot_r]  <= '0;
        count_r[slot_r] <= stage_len_r;
        live_r[slot_r]  <= stage_sum_r;
        total_r <= total_r
                   - (valid_r[slot_r] ? rrjd_pkg::TOTAL_W'(count_r[slot_r]) : '0)
                   + rrjd_pkg::TOTAL_W'(stage_len_r);
        // Every job's weight is refreshed from its live cost sum at a close.
        for (int s = 0; s < rrjd_pkg::MAX_JOBS; s++) begin
          weight_r[s] <= (rrjd_pkg::SLOT_W'(s) == slot_r) ? stage_sum_r : live_r[s];
        end
      end
      if (cmd.update) begin
        count_r[slot_r] <= count_r[slot_r] - 1'b1;
        if (rule_r[0]) begin
          head_r[slot_r] <= head_r[slot_r] + 1'b1;
        end
        live_r[slot_r] <= live_r[slot_r] - rrjd_pkg::WEIGHT_W'(mem_q_r.cost);
        total_r        <= total_r - 1'b1;
        if (last_op) begin
          valid_r[slot_r] <= 1'b0;
        end
        rot_r <= rot_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      ids_r[slot_r] <= stage_job_r;
    end
  end

  // ---------------- result ----------------
  always_comb begin
    res_nxt = res_r;
    if (cmd.add_eval) begin
      res_nxt        = '0;
      res_nxt.status = add_overflow ? rrjd_pkg::ST_FULL : rrjd_pkg::ST_ACCEPTED;
    end else if (cmd.pop_eval) begin
      res_nxt        = '0;
      res_nxt.status = rrjd_pkg::ST_EMPTY;
    end else if (cmd.find && !found) begin
      res_nxt.status = rrjd_pkg::ST_FULL;
    end else if (cmd.update) begin
      res_nxt.status     = rrjd_pkg::ST_ISSUED;
      res_nxt.out_job_id = pick_id_r;
      res_nxt.out_op_id  = mem_q_r.op;
      res_nxt.rule_used  = rule_r;
    end
    out_item_nxt               = res_r;
    out_item_nxt.remaining_ops = total_r;
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (cmd.load_out) begin
      out_item_r <= out_item_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    sts.is_pop       = in_q_r.req_type;
    sts.add_overflow = add_overflow;
    sts.add_last     = in_q_r.last_of_job;
    sts.pop_empty    = pop_empty;
    sts.scan_last    = (scan_r == rrjd_pkg::SLOT_W'(rrjd_pkg::MAX_JOBS - 1));
    sts.slot_found   = found;
    sts.copy_last    = (({1'b0, copy_r} + 1'b1) == stage_len_r);
    sts.out_free     = !out_valid_r || !out_stall;
  end

`ifndef SYNTHESIS
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= rrjd_pkg::TOTAL_W'(rrjd_pkg::MEM_DEPTH))
    else $error("stored operation total out of range");

  a_stage_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stage_len_r <= rrjd_pkg::CNT_W'(rrjd_pkg::MAX_OPS_PER_JOB))
    else $error("staging length out of range");

  a_pop_live_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |-> valid_r[slot_r] && (count_r[slot_r] != '0))
    else $error("pop issued from an empty job slot");

  a_commit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> stage_len_r != '0)
    else $error("close committed with no staged operations");
`endif

endmodule

[rtl/core/rotating_rule_job_dispatcher.sv]
// An add without close or an empty pop is decoded and then loaded into the result register;
// a pop scans every job slot in turn, then picks, reads and updates before loading the result.
// One transaction is in work at a time; a close finds a slot and copies the staged operations
// one by one into the operation memory before it commits.
// A finished result waits in the output register while the next transaction is accepted.
// Reset is synchronous and active low; the operation memory is not cleared.
`timescale 1ns / 1ps

module rotating_rule_job_dispatcher (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [rrjd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rrjd_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  rrjd_pkg::in_item_t             in_item,
  output logic                           out_valid,
  input  logic                           out_stall,
  output rrjd_pkg::out_item_t            out_item
);

  rrjd_pkg::cmd_t cmd;
  rrjd_pkg::sts_t sts;

  rrjd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rrjd_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

[test/tb_rotating_rule_job_dispatcher.sv]
// Self-checking testbench for the rotating-rule job dispatcher with its own predictor.
`timescale 1ns / 1ps

module tb_rotating_rule_job_dispatcher;

  localparam int NJ = rrjd_pkg::MAX_JOBS;
  localparam int NO = rrjd_pkg::MAX_OPS_PER_JOB;

  int fail_count = 0;

  task automatic report_mismatch(string msg);
    fail_count++;
    if (fail_count <= 40) $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  // Scoreboard: holds a copy of the dispatcher state and the queue of expected results.
  class dispatch_scoreboard;
    logic [rrjd_pkg::ID_W-1:0] slot_id [NJ];
    bit slot_used [NJ];
    rrjd_pkg::op_entry_t ops [NJ][NO];
    int unsigned head [NJ];
    int unsigned cnt [NJ];
    longint unsigned weight [NJ];
    int unsigned order [NJ];
    int unsigned order_len, rr_pos, rule, total;
    bit det_mode;
    logic [2:0] rule_cnt;
    logic [15:0] lfsr;
    logic [rrjd_pkg::ID_W-1:0] stage_job;
    int unsigned stage_len;
    rrjd_pkg::op_entry_t stage [NO];
    rrjd_pkg::out_item_t pending [$];
    int errors, checked, issued, empties, fulls;

    function void clear();
      for (int s = 0; s < NJ; s++) begin
        slot_used[s] = 0; head[s] = 0; cnt[s] = 0; weight[s] = 0; slot_id[s] = '0;
      end
      order_len = 0; rr_pos = 0; rule = 0; total = 0;
      det_mode = 1; rule_cnt = 3'd4; lfsr = 16'd1; stage_len = 0; stage_job = '0;
      errors = 0; checked = 0; issued = 0; empties = 0; fulls = 0;
    endfunction

    function void write_reg(logic [rrjd_pkg::CFG_IDX_W-1:0] idx,
                            logic [rrjd_pkg::CFG_W-1:0] d);
      case (idx)
        rrjd_pkg::CFG_DET_MODE:   det_mode = d[0];
        rrjd_pkg::CFG_RULE_COUNT: rule_cnt = d[2:0];
        rrjd_pkg::CFG_SEED:       lfsr = (d == 0) ? 16'd1 : d;
        default: ;
      endcase
    endfunction

    function int unsigned jobs_held();
      int unsigned n = 0;
      for (int s = 0; s < NJ; s++) if (slot_used[s]) n++;
      return n;
    endfunction

    function int unsigned slot_at_rank(int unsigned k);
      int unsigned first = 0, r;
      bit seen = 0;
      for (int s = 0; s < NJ; s++) begin
        if (!slot_used[s]) continue;
        if (!seen) begin first = s; seen = 1; end
        r = 0;
        for (int t = 0; t < NJ; t++) if (slot_used[t] && slot_id[t] < slot_id[s]) r++;
        if (r == k) return s;
      end
      return first;
    endfunction

    function bit is_lighter(int unsigned a, int unsigned b);
      if (weight[a] != weight[b]) return weight[a] < weight[b];
      return slot_id[a] < slot_id[b];
    endfunction

    function void reorder();
      longint unsigned w;
      int unsigned j;
      order_len = 0;
      for (int s = 0; s < NJ; s++) begin
        if (!slot_used[s]) continue;
        w = 0;
        for (int i = 0; i < cnt[s]; i++) w += ops[s][(head[s] + i) % NO].cost;
        weight[s] = w;
        j = order_len;
        while (j > 0 && is_lighter(s, order[j-1])) begin
          order[j] = order[j-1]; j--;
        end
        order[j] = s;
        order_len++;
      end
    endfunction

    function rrjd_pkg::status_t close_job();
      int unsigned slot = NJ, j;
      rrjd_pkg::op_entry_t v;
      for (int s = 0; s < NJ; s++)
        if (slot == NJ && slot_used[s] && slot_id[s] == stage_job) slot = s;
      for (int s = 0; s < NJ; s++)
        if (slot == NJ && !slot_used[s]) slot = s;
      if (slot == NJ) begin
        stage_len = 0;
        return rrjd_pkg::ST_FULL;
      end
      if (slot_used[slot]) total -= cnt[slot];
      // Insertion sort keeps equal costs in arrival order.
      for (int i = 0; i < stage_len; i++) begin
        v = stage[i]; j = i;
        while (j > 0 && ops[slot][j-1].cost > v.cost) begin
          ops[slot][j] = ops[slot][j-1]; j--;
        end
        ops[slot][j] = v;
      end
      slot_id[slot] = stage_job; slot_used[slot] = 1;
      head[slot] = 0; cnt[slot] = stage_len;
      total += stage_len; stage_len = 0;
      reorder();
      return rrjd_pkg::ST_ACCEPTED;
    endfunction

    function void note_input(rrjd_pkg::in_item_t it);
      rrjd_pkg::out_item_t r;
      int unsigned n, slot, idx;
      rrjd_pkg::op_entry_t v;
      r = '0;
      if (!it.req_type) begin
        if (stage_len > 0 && stage_job != it.job_id) stage_len = 0;
        if (stage_len >= NO) begin
          stage_len = 0; r.status = rrjd_pkg::ST_FULL;
        end else begin
          stage_job = it.job_id;
          stage[stage_len].cost = it.op_cost; stage[stage_len].op = it.op_id;
          stage_len++;
          r.status = it.last_of_job ? close_job() : rrjd_pkg::ST_ACCEPTED;
        end
        if (r.status == rrjd_pkg::ST_FULL) fulls++;
      end else if (total == 0 || jobs_held() == 0) begin
        r.status = rrjd_pkg::ST_EMPTY; empties++;
      end else begin
        n = (rule_cnt == 0) ? 1 : (rule_cnt > 4) ? 4 : rule_cnt;
        if (det_mode) rule = (rule + 1) % n;
        else begin
          lfsr = lfsr[0] ? ((lfsr >> 1) ^ rrjd_pkg::LFSR_TAPS) : (lfsr >> 1);
          rule = lfsr % n;
        end
        n = jobs_held();
        slot = (rule < 2 && order_len > 0) ? order[0] : slot_at_rank(rr_pos % n);
        if (rule == 0 || rule == 2) idx = (head[slot] + cnt[slot] - 1) % NO;
        else begin
          idx = head[slot]; head[slot] = (head[slot] + 1) % NO;
        end
        v = ops[slot][idx];
        cnt[slot]--; total--;
        if (cnt[slot] == 0) begin
          slot_used[slot] = 0;
          for (int i = 0; i < order_len; i++)
            if (order[i] == slot) begin
              for (int k = i + 1; k < order_len; k++) order[k-1] = order[k];
              order_len--;
              break;
            end
        end
        n = jobs_held();
        if (n == 0) rr_pos = 0;
        else if (rule < 2) rr_pos = rr_pos % n;
        else rr_pos = (rr_pos + 1) % n;
        r.status = rrjd_pkg::ST_ISSUED; r.out_job_id = slot_id[slot]; r.out_op_id = v.op;
        r.rule_used = rule[1:0]; issued++;
      end
      r.remaining_ops = total[rrjd_pkg::TOTAL_W-1:0];
      pending.insert(pending.size(), r);
    endfunction

    task check_result(rrjd_pkg::out_item_t got);
      rrjd_pkg::out_item_t e;
      checked++;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: %p", got));
        return;
      end
      e = pending[0];
      pending.delete(0);
      if (got.status !== e.status)
        report_mismatch($sformatf("status got %0d exp %0d", got.status, e.status));
      if (got.out_job_id !== e.out_job_id)
        report_mismatch($sformatf("job got %0h exp %0h", got.out_job_id, e.out_job_id));
      if (got.out_op_id !== e.out_op_id)
        report_mismatch($sformatf("op got %0h exp %0h", got.out_op_id, e.out_op_id));
      if (got.rule_used !== e.rule_used)
        report_mismatch($sformatf("rule got %0d exp %0d", got.rule_used, e.rule_used));
      if (got.remaining_ops !== e.remaining_ops)
        report_mismatch($sformatf("remaining got %0d exp %0d",
                                  got.remaining_ops, e.remaining_ops));
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [rrjd_pkg::CFG_IDX_W-1:0] cfg_index = rrjd_pkg::CFG_DET_MODE;
  logic [rrjd_pkg::CFG_W-1:0] cfg_wdata = '0;
  logic in_valid = 0;
  logic in_stall;
  rrjd_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 0;
  rrjd_pkg::out_item_t out_item;

  dispatch_scoreboard sb;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 0;
  logic [rrjd_pkg::ID_W-1:0] next_op = '0;

  rotating_rule_job_dispatcher i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  function automatic rrjd_pkg::in_item_t rand_item();
    logic [95:0] bits;
    bits = {$urandom, $urandom, $urandom};
    return bits[$bits(rrjd_pkg::in_item_t)-1:0];
  endfunction

  // Receiver: stall pattern chosen at each falling edge, results checked at rising edges.
  always @(negedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
  end

  task automatic send_item(rrjd_pkg::in_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(it);
    @(negedge clk);
    in_valid <= 1'b0;
    in_item <= rand_item();
  endtask

  task automatic add_op(logic [rrjd_pkg::ID_W-1:0] job,
                        logic [rrjd_pkg::COST_W-1:0] cost, bit last);
    rrjd_pkg::in_item_t it;
    it.req_type = 1'b0; it.job_id = job; it.op_id = next_op;
    it.op_cost = cost; it.last_of_job = last;
    next_op = next_op + 1'b1;
    send_item(it);
  endtask

  task automatic pop_op();
    rrjd_pkg::in_item_t it;
    it = rand_item();
    it.req_type = 1'b1;
    send_item(it);
  endtask

  task automatic drain();
    int guard = 0;
    while (sb.pending.size() != 0 && guard < 200000) begin
      @(posedge clk); guard++;
    end
    repeat (40) @(posedge clk);
  endtask

  task automatic write_cfg(logic [rrjd_pkg::CFG_IDX_W-1:0] idx,
                           logic [rrjd_pkg::CFG_W-1:0] d);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= d;
    @(posedge clk);
    sb.write_reg(idx, d);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // A job of random size; a small chance of junk that breaks staging.
  task automatic random_job(int max_len);
    logic [rrjd_pkg::ID_W-1:0] job;
    int len;
    job = ($urandom_range(9) == 0) ? rrjd_pkg::ID_W'($urandom)
                                   : rrjd_pkg::ID_W'($urandom_range(23));
    len = $urandom_range(max_len, 1);
    for (int i = 0; i < len; i++) begin
      add_op(job, ($urandom_range(3) == 0) ? rrjd_pkg::COST_W'($urandom)
                                           : rrjd_pkg::COST_W'($urandom_range(40)),
             (i == len - 1) && ($urandom_range(11) != 0));
      if ($urandom_range(40) == 0) pop_op();
    end
  endtask

  task automatic random_phase(int items);
    int sent = 0;
    while (sent < items) begin
      if ($urandom_range(2) == 0) begin
        pop_op(); sent++;
      end else begin
        random_job(($urandom_range(15) == 0) ? 18 : 5);
        sent += 3;
      end
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty pop, extremes, sort ties, replacement, overflow, slot exhaustion.
    pop_op();
    add_op(16'hFFFF, 20'hFFFFF, 0);
    add_op(16'hFFFF, 20'd0, 0);
    add_op(16'hFFFF, 20'd5, 0);
    add_op(16'hFFFF, 20'd5, 1);
    add_op(16'h0000, 20'd7, 1);
    add_op(16'h0000, 20'd3, 0);
    add_op(16'h0001, 20'd2, 1);
    for (int i = 0; i < 17; i++) add_op(16'h0042, rrjd_pkg::COST_W'(i), 0);
    add_op(16'h0042, 20'd1, 1);
    for (int i = 0; i < 5; i++) pop_op();
    drain();
    write_cfg(rrjd_pkg::CFG_DET_MODE, 16'd1);
    write_cfg(rrjd_pkg::CFG_RULE_COUNT, 16'd0);
    write_cfg(rrjd_pkg::CFG_SEED, 16'd0);
    for (int j = 0; j < 17; j++) add_op(rrjd_pkg::ID_W'(100 + j), 20'd9, 1);
    while (sb.total > 0) pop_op();
    drain();

    // Random phases over register settings and idling patterns.
    for (int ph = 0; ph < 12; ph++) begin
      write_cfg(rrjd_pkg::CFG_DET_MODE, rrjd_pkg::CFG_W'(ph % 3 != 0 ? 0 : 1));
      write_cfg(rrjd_pkg::CFG_RULE_COUNT, rrjd_pkg::CFG_W'(ph % 8));
      write_cfg(rrjd_pkg::CFG_SEED, (ph == 5) ? 16'hFFFF : rrjd_pkg::CFG_W'($urandom));
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      if (ph == 6) begin
        fork
          begin
            hold_off = 1;
            repeat (600) @(posedge clk);
            hold_off = 0;
          end
          random_phase(95);
        join
      end else begin
        random_phase(95);
      end
      drain();
    end

    $display("Covered adds, closes, pops, overflow and full-store cases under all rule counts;");
    $display("%0d results checked: %0d issued, %0d empty, %0d full.",
             sb.checked, sb.issued, sb.empties, sb.fulls);
    if (fail_count == 0 && sb.pending.size() == 0) begin
      $display("tb_rotating_rule_job_dispatcher: clean");
    end else begin
      $display("tb_rotating_rule_job_dispatcher: errors");
    end
    $finish;
  end

  initial begin
    #6ms;
    $display("tb_rotating_rule_job_dispatcher: errors");
    $finish;
  end

endmodule
